### src/llci_pkg.sv
// Package: shared constants, status codes and unit request/response types.
package llci_pkg;

    localparam int NODES     = 16;
    localparam int IDX_W     = $clog2(NODES);
    localparam int CNT_W     = $clog2(NODES + 1);
    localparam int CFG_W     = 5;

    localparam int FRAC_BITS = 40;
    localparam int LOG_W     = FRAC_BITS + 5;
    localparam int PROD_W    = LOG_W + 32;
    localparam int TAYLOR_N  = 30;

    localparam int MUL_W     = 64;
    localparam int DVD_W     = 128;
    localparam int DEN_W     = 32;
    localparam int DCNT_W    = 7;

    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_REJECTED = 3'd1;
    localparam logic [2:0] ST_IN_RANGE = 3'd2;
    localparam logic [2:0] ST_BEFORE   = 3'd3;
    localparam logic [2:0] ST_BEYOND   = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [2*MUL_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
        logic [DCNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MUL_W-1:0] quot;
    } t_div_rsp;

endpackage

### src/llci_if.sv
// Interfaces: input item channel and result channel.
interface llci_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  node_index;
    logic [31:0] node_horizon;
    logic [31:0] node_rate;
    logic [31:0] query_horizon;

    modport source (output valid, action, node_index, node_horizon, node_rate,
                    query_horizon, input ready);
    modport sink (input valid, action, node_index, node_horizon, node_rate,
                  query_horizon, output ready);
endinterface

interface llci_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rate;
    logic [2:0]  status;

    modport source (output valid, rate, status, input ready);
    modport sink (input valid, rate, status, output ready);
endinterface

### src/log_linear_curve_interpolator_unit.sv
// Top level: curve node store, node search and log-linear interpolation sequencer.
//
// Input channel i_in (valid/ready): action 0 loads node_index with
// node_horizon/node_rate, action 1 asks for the rate at query_horizon.
// Result channel o_out (valid/ready): rate (Q16.16) and status per item.
// i_cfg_we/i_cfg_wdata write node_count; write it only while idle.
// One item is in flight at a time; i_in.ready is high only when the
// sequencer is idle. A load goes straight to the final state. A flat query
// (empty, before first, beyond last) needs no arithmetic; a bracketed query
// also scans the nodes in order. Interpolation adds two log2 evaluations of
// 40 squarings each on the shared multiplier, a serial divide for the weight,
// and up to 30 Taylor terms (a multiply plus a serial divide each); the
// shared multiplier and divider set the run time of an interpolation.
// Results sit in an output register; if the receiver stalls, the finished
// result waits there and the next result waits in the final state.
// Reset (synchronous, active low) clears node_count and the control state;
// node contents are undefined until loaded.
module log_linear_curve_interpolator_unit import llci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    llci_in_if.sink           i_in,
    llci_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_FIRST     = 5'd1;
    localparam logic [4:0] S_LAST      = 5'd2;
    localparam logic [4:0] S_SCAN      = 5'd3;
    localparam logic [4:0] S_PAIR      = 5'd4;
    localparam logic [4:0] S_LGO       = 5'd5;
    localparam logic [4:0] S_LWAIT     = 5'd6;
    localparam logic [4:0] S_LEND      = 5'd7;
    localparam logic [4:0] S_DMUL_GO   = 5'd8;
    localparam logic [4:0] S_DMUL_WAIT = 5'd9;
    localparam logic [4:0] S_DIV_GO    = 5'd10;
    localparam logic [4:0] S_DIV_WAIT  = 5'd11;
    localparam logic [4:0] S_YGO       = 5'd12;
    localparam logic [4:0] S_YWAIT     = 5'd13;
    localparam logic [4:0] S_TCHK      = 5'd14;
    localparam logic [4:0] S_TMUL_WAIT = 5'd15;
    localparam logic [4:0] S_TDIV_GO   = 5'd16;
    localparam logic [4:0] S_TDIV_WAIT = 5'd17;
    localparam logic [4:0] S_FIN       = 5'd18;
    localparam logic [4:0] S_DONE      = 5'd19;

    // control
    logic [4:0]       r_state;
    logic [CFG_W-1:0] r_node_count;
    logic             r_o_valid;
    logic             r_which;
    logic [5:0]       r_k;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_last;

    // payload
    logic [31:0]      r_qh, r_h0, r_r0, r_h1, r_r1;
    logic [63:0]      r_m;
    logic [4:0]       r_n;
    logic [FRAC_BITS-1:0] r_frac;
    logic [LOG_W-1:0] r_l0, r_l1, r_lsum;
    logic [63:0]      r_y, r_term, r_s;
    logic [31:0]      r_res_rate, r_o_rate;
    logic [2:0]       r_res_status, r_o_status;

    // node store
    logic [63:0]      mem [NODES];
    logic [63:0]      r_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic             in_xfer;
    logic [CNT_W-1:0] cnt;
    logic             load_ok;
    logic [31:0]      log_src, log_x;
    logic [4:0]       log_n;
    logic [63:0]      log_m;
    logic [63:0]      sq_m;
    logic             up;
    logic [LOG_W-1:0] dlog;
    logic [LOG_W-1:0] q_w;
    logic [4:0]       ip;
    logic [63:0]      s_hi, s_rb;
    logic [33:0]      fin;

    llci_mul u_mul (.i_clk, .i_rst_n, .i_req(mul_req), .o_rsp(mul_rsp));
    llci_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    assign in_xfer = i_in.valid && i_in.ready;
    assign cnt = (32'(r_node_count) > NODES) ? CNT_W'(NODES) : CNT_W'(r_node_count);
    assign load_ok = (i_in.node_rate != 32'd0) && (CNT_W'(i_in.node_index) < cnt);
    assign mem_we = in_xfer && (i_in.action == ACT_LOAD) && load_ok;

    // read data is registered: it arrives in the cycle after its address
    always_comb begin
        unique case (r_state)
            S_FIRST: rd_addr = r_last;
            S_LAST:  rd_addr = IDX_W'(1);
            S_SCAN:  rd_addr = r_i + IDX_W'(1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[i_in.node_index[IDX_W-1:0]] <= {i_in.node_horizon, i_in.node_rate};
        end
        r_rd <= mem[rd_addr];
    end

    // log2 setup: msb index and mantissa alignment
    always_comb begin
        log_src = (r_state == S_LEND) ? r_r1 : r_r0;
        log_x   = (log_src == 32'd0) ? 32'd1 : log_src;
        log_n   = 5'd0;
        for (int b = 1; b < 32; b++) begin
            if (log_x[b]) begin
                log_n = 5'(b);
            end
        end
        log_m = 64'(log_x) << (6'd62 - 6'(log_n));
    end

    assign sq_m = mul_rsp.prod[125:62];
    assign up   = r_l1 >= r_l0;
    assign dlog = up ? (r_l1 - r_l0) : (r_l0 - r_l1);
    assign q_w  = div_rsp.quot[LOG_W-1:0];
    assign ip   = r_lsum[LOG_W-1:FRAC_BITS];

    // 2^int * (1+s), rounded half up
    always_comb begin
        s_hi = r_s >> (7'd64 - 7'(ip));
        s_rb = r_s >> (7'd63 - 7'(ip));
        fin  = 34'd1 << ip;
        if (ip != 5'd0) begin
            fin = fin + s_hi[33:0];
        end
        fin = fin + 34'(s_rb[0]);
    end

    // shared unit operand select
    always_comb begin
        mul_req = '0;
        div_req = '0;
        unique case (r_state)
            S_LGO: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_m;
                mul_req.b     = r_m;
            end
            S_DMUL_GO: begin
                mul_req.start = 1'b1;
                mul_req.a     = 64'(dlog);
                mul_req.b     = 64'(r_qh - r_h0);
            end
            S_YGO: begin
                mul_req.start = 1'b1;
                mul_req.a     = {r_lsum[FRAC_BITS-1:0], (64 - FRAC_BITS)'(0)};
                mul_req.b     = LN2_Q64;
            end
            S_TCHK: begin
                mul_req.start = (r_k <= 6'(TAYLOR_N)) && (r_term != 64'd0);
                mul_req.a     = r_term;
                mul_req.b     = r_y;
            end
            S_DIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_rsp.prod[PROD_W-1:0], (DVD_W - PROD_W)'(0)};
                div_req.divisor  = r_h1 - r_h0;
                div_req.count    = DCNT_W'(PROD_W);
            end
            S_TDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {mul_rsp.prod[127:64], 64'd0};
                div_req.divisor  = 32'(r_k) + 32'd1;
                div_req.count    = DCNT_W'(64);
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= '0;
            r_o_valid    <= 1'b0;
            r_which      <= 1'b0;
            r_k          <= '0;
            r_i          <= '0;
            r_last       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            // output register: load from the final state, clear on transfer
            if (r_state == S_DONE && (!r_o_valid || o_out.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_last <= IDX_W'(cnt - CNT_W'(1));
                        if (i_in.action == ACT_LOAD || cnt == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_FIRST;
                        end
                    end
                end
                S_FIRST: begin
                    if (r_qh > r_rd[63:32]) begin
                        r_state <= S_LAST;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_LAST: begin
                    r_i <= IDX_W'(1);
                    r_state <= (r_qh >= r_rd[63:32]) ? S_DONE : S_SCAN;
                end
                S_SCAN: begin
                    if (r_qh <= r_rd[63:32] || r_i == r_last) begin
                        r_state <= S_PAIR;
                    end else begin
                        r_i <= r_i + IDX_W'(1);
                    end
                end
                S_PAIR: begin
                    r_which <= 1'b0;
                    r_k     <= '0;
                    if (r_qh == r_h1 || r_h1 <= r_h0 || r_qh <= r_h0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LGO;
                    end
                end
                S_LGO: begin
                    r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (mul_rsp.done) begin
                        r_k <= r_k + 6'd1;
                        r_state <= (r_k == 6'(FRAC_BITS - 1)) ? S_LEND : S_LGO;
                    end
                end
                S_LEND: begin
                    r_k <= '0;
                    if (!r_which) begin
                        r_which <= 1'b1;
                        r_state <= S_LGO;
                    end else begin
                        r_state <= S_DMUL_GO;
                    end
                end
                S_DMUL_GO:   r_state <= S_DMUL_WAIT;
                S_DMUL_WAIT: if (mul_rsp.done) r_state <= S_DIV_GO;
                S_DIV_GO:    r_state <= S_DIV_WAIT;
                S_DIV_WAIT:  if (div_rsp.done) r_state <= S_YGO;
                S_YGO:       r_state <= S_YWAIT;
                S_YWAIT: begin
                    if (mul_rsp.done) begin
                        r_k <= 6'd1;
                        r_state <= S_TCHK;
                    end
                end
                S_TCHK: begin
                    r_state <= mul_req.start ? S_TMUL_WAIT : S_FIN;
                end
                S_TMUL_WAIT: if (mul_rsp.done) r_state <= S_TDIV_GO;
                S_TDIV_GO:   r_state <= S_TDIV_WAIT;
                S_TDIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_k <= r_k + 6'd1;
                        r_state <= S_TCHK;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_qh <= i_in.query_horizon;
                r_res_rate <= 32'd0;
                if (i_in.action == ACT_LOAD) begin
                    r_res_status <= load_ok ? ST_STORED : ST_REJECTED;
                end else begin
                    r_res_status <= ST_EMPTY;
                end
            end
            S_FIRST: begin
                r_h0 <= r_rd[63:32];
                r_r0 <= r_rd[31:0];
                r_res_rate <= r_rd[31:0];
                r_res_status <= (r_qh < r_rd[63:32]) ? ST_BEFORE : ST_IN_RANGE;
            end
            S_LAST: begin
                r_res_rate <= r_rd[31:0];
                r_res_status <= (r_qh > r_rd[63:32]) ? ST_BEYOND : ST_IN_RANGE;
            end
            S_SCAN: begin
                r_res_status <= ST_IN_RANGE;
                if (r_qh <= r_rd[63:32] || r_i == r_last) begin
                    r_h1 <= r_rd[63:32];
                    r_r1 <= r_rd[31:0];
                end else begin
                    r_h0 <= r_rd[63:32];
                    r_r0 <= r_rd[31:0];
                end
            end
            S_PAIR: begin
                r_res_rate <= (r_qh == r_h1) ? r_r1 : r_r0;
                r_m    <= log_m;
                r_n    <= log_n;
                r_frac <= '0;
            end
            S_LWAIT: begin
                if (mul_rsp.done) begin
                    r_frac <= {r_frac[FRAC_BITS-2:0], sq_m[63]};
                    r_m    <= sq_m[63] ? (sq_m >> 1) : sq_m;
                end
            end
            S_LEND: begin
                if (!r_which) begin
                    r_l0 <= {r_n, r_frac};
                end else begin
                    r_l1 <= {r_n, r_frac};
                end
                r_m    <= log_m;
                r_n    <= log_n;
                r_frac <= '0;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    r_lsum <= up ? (r_l0 + q_w) : (r_l0 - q_w);
                end
            end
            S_YWAIT: begin
                if (mul_rsp.done) begin
                    r_y    <= mul_rsp.prod[127:64];
                    r_term <= mul_rsp.prod[127:64];
                    r_s    <= 64'd0;
                end
            end
            S_TCHK: begin
                if (mul_req.start) begin
                    r_s <= r_s + r_term;
                end
            end
            S_TDIV_WAIT: begin
                if (div_rsp.done) begin
                    r_term <= div_rsp.quot;
                end
            end
            S_FIN: begin
                r_res_rate <= (fin[33:32] != 2'd0) ? 32'hFFFF_FFFF : fin[31:0];
            end
            S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    r_o_rate   <= r_res_rate;
                    r_o_status <= r_res_status;
                end
            end
            default: begin
                r_res_rate <= r_res_rate;
            end
        endcase
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_o_valid;
    assign o_out.rate   = r_o_rate;
    assign o_out.status = r_o_status;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in.ready)
        else $error("second item taken while busy");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result issued outside final state");
    a_load_no_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in.action == ACT_LOAD |=> r_state == S_DONE)
        else $error("load entered the search");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_status <= ST_EMPTY)
        else $error("status code out of range");

endmodule

### src/llci_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier over four passes.
module llci_mul import llci_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic               r_pv;
    logic [2:0]         r_cnt;
    logic [MUL_W-1:0]   r_a;
    logic [MUL_W-1:0]   r_b;
    logic [63:0]        r_p;
    logic [1:0]         r_psh;
    logic [2*MUL_W-1:0] r_acc;

    logic [31:0]        a_half;
    logic [31:0]        b_half;
    logic [2*MUL_W-1:0] p_shifted;

    always_comb begin
        a_half = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        b_half = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        unique case (r_psh)
            2'd0:    p_shifted = {64'd0, r_p};
            2'd1:    p_shifted = {32'd0, r_p, 32'd0};
            default: p_shifted = {r_p, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_pv  <= !r_cnt[2];
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt[2]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product register, then accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (!r_cnt[2]) begin
                r_p   <= 64'(a_half * b_half);
                r_psh <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
            end
            if (r_pv) begin
                r_acc <= r_acc + p_shifted;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiplier started while busy");
    a_mul_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("multiplier done without a pass");
    a_mul_pv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_busy)
        else $error("partial product pending while idle");

endmodule

### src/llci_div.sv
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
module llci_div import llci_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [MUL_W-1:0]  r_q;

    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[MUL_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && i_req.count != '0 && i_req.divisor != '0)
        else $error("bad divider start");
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_req.start) |-> r_rem < r_den)
        else $error("remainder not below divisor");
    a_div_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held");

endmodule
